@@ hdl/triangle_supersample_coverage_assert.svh @@
// Assertion macros shared by the coverage block.
`ifndef TRIANGLE_SUPERSAMPLE_COVERAGE_ASSERT_SVH
`define TRIANGLE_SUPERSAMPLE_COVERAGE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TSS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define TSS_ASSERT(label, clk, rstn, prop, msg)
`define TSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ hdl/tss_pkg.sv @@
package tss_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int MAX_GRID_SIDE_DEF = 4;

    localparam int CFG_AW    = 5;
    localparam int CFG_DW    = 32;
    localparam int ACTION_W  = 2;
    localparam int ALPHA_W   = 8;
    localparam int COVERED_W = 5;

    typedef enum logic [2:0] {
        REG_VERTEX_AX = 3'd0,
        REG_VERTEX_AY = 3'd1,
        REG_VERTEX_BX = 3'd2,
        REG_VERTEX_BY = 3'd3,
        REG_VERTEX_CX = 3'd4,
        REG_VERTEX_CY = 3'd5,
        REG_GRID_MODE = 3'd6
    } tss_reg_t;

    typedef enum logic [1:0] {
        GRID_1 = 2'd0,
        GRID_2 = 2'd1,
        GRID_4 = 2'd2
    } tss_grid_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SKIP  = 2'd0,
        ACT_FULL  = 2'd1,
        ACT_BLEND = 2'd2
    } tss_action_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } tss_stage_en_t;

    // Largest supported log2 of the grid side for a given maximum side.
    function automatic int cap_log(int max_side);
        int r;
        if (max_side >= 4) begin
            r = 2;
        end else if (max_side >= 2) begin
            r = 1;
        end else begin
            r = 0;
        end
        return r;
    endfunction

    // Grid mode code to log2 of the grid side, limited by the build maximum.
    function automatic logic [1:0] side_log(logic [1:0] mode, logic [1:0] cap);
        logic [1:0] s;
        case (tss_grid_t'(mode))
            GRID_1:  s = 2'd0;
            GRID_2:  s = 2'd1;
            default: s = 2'd2;
        endcase
        if (s > cap) begin
            s = cap;
        end
        return s;
    endfunction

endpackage

@@ hdl/tss_edge_stage.sv @@
module tss_edge_stage #(
    parameter int COORD_BITS    = tss_pkg::COORD_BITS_DEF,
    parameter int MAX_GRID_SIDE = tss_pkg::MAX_GRID_SIDE_DEF
) (
    input  logic                          aclk,
    input  tss_pkg::tss_stage_en_t        en,
    input  logic signed [COORD_BITS-1:0]  px,
    input  logic signed [COORD_BITS-1:0]  py,
    input  logic signed [COORD_BITS-1:0]  ux,
    input  logic signed [COORD_BITS-1:0]  uy,
    input  logic signed [COORD_BITS-1:0]  vx,
    input  logic signed [COORD_BITS-1:0]  vy,
    input  logic [1:0]                    side_log,
    output logic [(1 << (2*tss_pkg::cap_log(MAX_GRID_SIDE)))-1:0] neg,
    output logic [(1 << (2*tss_pkg::cap_log(MAX_GRID_SIDE)))-1:0] pos
);

    localparam int W      = COORD_BITS;
    localparam int DW     = W + 1;
    localparam int PW     = 2*W + 2;
    localparam int KW     = 2*W + 3;
    localparam int EW     = 2*W + 7;
    localparam int SIDE_N = 1 << tss_pkg::cap_log(MAX_GRID_SIDE);
    localparam int NSLOT  = SIDE_N * SIDE_N;

    logic signed [DW-1:0] rx, ry, dx, dy;
    logic signed [PW-1:0] prod_a_next, prod_b_next, prod_a_reg, prod_b_reg;
    logic signed [KW-1:0] k_next, k_reg;
    logic signed [EW-1:0] dx_e, dy_e, k8;
    logic [NSLOT-1:0]     neg_next, pos_next, neg_reg, pos_reg;

    assign rx = DW'(px) - DW'(vx);
    assign ry = DW'(py) - DW'(vy);
    assign dx = DW'(ux) - DW'(vx);
    assign dy = DW'(uy) - DW'(vy);

    always_comb begin
        prod_a_next = PW'(rx) * PW'(dy);
        prod_b_next = PW'(dx) * PW'(ry);
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    assign k_next = KW'(prod_a_reg) - KW'(prod_b_reg);

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            k_reg <= k_next;
        end
    end

    // The edge value at a subsample is the pixel-corner value plus the
    // offset of the subsample times the edge direction.
    assign dx_e = EW'(dx);
    assign dy_e = EW'(dy);
    assign k8   = EW'(k_reg) <<< 3;

    for (genvar g = 0; g < NSLOT; g++) begin : g_slot
        localparam int IX = g % SIDE_N;
        localparam int IY = g / SIDE_N;
        logic [2:0]           ox, oy;
        logic signed [EW-1:0] tx, ty, e;

        assign ox = 3'(4'(2*IX + 1) << (2'd2 - side_log));
        assign oy = 3'(4'(2*IY + 1) << (2'd2 - side_log));
        assign tx = (ox[0] ? dy_e : '0) + (ox[1] ? (dy_e <<< 1) : '0)
                  + (ox[2] ? (dy_e <<< 2) : '0);
        assign ty = (oy[0] ? dx_e : '0) + (oy[1] ? (dx_e <<< 1) : '0)
                  + (oy[2] ? (dx_e <<< 2) : '0);
        assign e  = k8 + tx - ty;
        assign neg_next[g] = e[EW-1];
        assign pos_next[g] = ~e[EW-1] & (|e);
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            neg_reg <= neg_next;
            pos_reg <= pos_next;
        end
    end

    assign neg = neg_reg;
    assign pos = pos_reg;

endmodule

@@ hdl/triangle_supersample_coverage.sv @@
// Throughput: one beat per cycle through a five-register pipeline (input, edge products,
// edge constants, subsample signs, result); a stalled result register backs up the stages.
// Reset (synchronous, active low) empties the pipeline and sets all vertices to zero
// and grid_mode to four subsamples per side.
`include "triangle_supersample_coverage_assert.svh"

module triangle_supersample_coverage #(
    parameter int COORD_BITS    = tss_pkg::COORD_BITS_DEF,
    parameter int MAX_GRID_SIDE = tss_pkg::MAX_GRID_SIDE_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tss_pkg::CFG_AW-1:0]           paddr,
    input  logic [tss_pkg::CFG_DW-1:0]           pwdata,
    output logic [tss_pkg::CFG_DW-1:0]           prdata,
    output logic                                 pready,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pix_x, pix_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_x, out_y, alpha, covered
    output logic [((2*COORD_BITS+20)/8)*8-1:0]   m_tdata,
    // action
    output logic [tss_pkg::ACTION_W-1:0]         m_tuser
);

    localparam int W       = COORD_BITS;
    localparam int M_DW    = ((2*COORD_BITS+20)/8)*8;
    localparam int PAD_W   = M_DW - (2*W + tss_pkg::ALPHA_W + tss_pkg::COVERED_W);
    localparam int CAP_LOG = tss_pkg::cap_log(MAX_GRID_SIDE);
    localparam int SIDE_N  = 1 << CAP_LOG;
    localparam int NSLOT   = SIDE_N * SIDE_N;
    localparam int CW      = tss_pkg::COVERED_W;

    logic [W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [W-1:0] ax_next, ay_next, bx_next, by_next, cx_next, cy_next;
    logic [1:0]   grid_mode_reg, grid_mode_next;
    logic         cfg_wr;
    logic [1:0]   sl;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        grid_mode_next = grid_mode_reg;
        if (cfg_wr) begin
            case (tss_pkg::tss_reg_t'(paddr[4:2]))
                tss_pkg::REG_VERTEX_AX: ax_next = pwdata[W-1:0];
                tss_pkg::REG_VERTEX_AY: ay_next = pwdata[W-1:0];
                tss_pkg::REG_VERTEX_BX: bx_next = pwdata[W-1:0];
                tss_pkg::REG_VERTEX_BY: by_next = pwdata[W-1:0];
                tss_pkg::REG_VERTEX_CX: cx_next = pwdata[W-1:0];
                tss_pkg::REG_VERTEX_CY: cy_next = pwdata[W-1:0];
                tss_pkg::REG_GRID_MODE: grid_mode_next = pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg        <= '0;
            ay_reg        <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            grid_mode_reg <= tss_pkg::GRID_4;
        end else begin
            ax_reg        <= ax_next;
            ay_reg        <= ay_next;
            bx_reg        <= bx_next;
            by_reg        <= by_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            grid_mode_reg <= grid_mode_next;
        end
    end

    always_comb begin
        case (tss_pkg::tss_reg_t'(paddr[4:2]))
            tss_pkg::REG_VERTEX_AX: prdata = tss_pkg::CFG_DW'(ax_reg);
            tss_pkg::REG_VERTEX_AY: prdata = tss_pkg::CFG_DW'(ay_reg);
            tss_pkg::REG_VERTEX_BX: prdata = tss_pkg::CFG_DW'(bx_reg);
            tss_pkg::REG_VERTEX_BY: prdata = tss_pkg::CFG_DW'(by_reg);
            tss_pkg::REG_VERTEX_CX: prdata = tss_pkg::CFG_DW'(cx_reg);
            tss_pkg::REG_VERTEX_CY: prdata = tss_pkg::CFG_DW'(cy_reg);
            tss_pkg::REG_GRID_MODE: prdata = tss_pkg::CFG_DW'(grid_mode_reg);
            default:                prdata = '0;
        endcase
    end

    assign sl = tss_pkg::side_log(grid_mode_reg, 2'(CAP_LOG));

    // Pipeline control: a stage advances when it is empty or the next one advances.
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic v0_next, v1_next, v2_next, v3_next, v4_next;
    logic en0, en1, en2, en3, en4;
    tss_pkg::tss_stage_en_t stage_en;

    assign en4 = ~v4_reg | m_tready;
    assign en3 = ~v3_reg | en4;
    assign en2 = ~v2_reg | en3;
    assign en1 = ~v1_reg | en2;
    assign en0 = ~v0_reg | en1;
    assign s_tready = en0;

    assign stage_en = '{s1: en1, s2: en2, s3: en3};

    always_comb begin
        v0_next = en0 ? s_tvalid : v0_reg;
        v1_next = en1 ? v0_reg   : v1_reg;
        v2_next = en2 ? v1_reg   : v2_reg;
        v3_next = en3 ? v2_reg   : v3_reg;
        v4_next = en4 ? v3_reg   : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    logic [W-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic [W-1:0] x4_reg, y4_reg;

    always_ff @(posedge aclk) begin
        if (en0) begin
            x0_reg <= s_tdata[W-1:0];
            y0_reg <= s_tdata[2*W-1:W];
        end
        if (en1) begin
            x1_reg <= x0_reg;
            y1_reg <= y0_reg;
        end
        if (en2) begin
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
        end
        if (en3) begin
            x3_reg <= x2_reg;
            y3_reg <= y2_reg;
        end
        if (en4) begin
            x4_reg <= x3_reg;
            y4_reg <= y3_reg;
        end
    end

    logic [NSLOT-1:0] neg_ab, pos_ab, neg_bc, pos_bc, neg_ca, pos_ca;

    tss_edge_stage #(.COORD_BITS(COORD_BITS), .MAX_GRID_SIDE(MAX_GRID_SIDE)) u_edge_ab (
        .aclk(aclk), .en(stage_en), .px(x0_reg), .py(y0_reg),
        .ux(ax_reg), .uy(ay_reg), .vx(bx_reg), .vy(by_reg),
        .side_log(sl), .neg(neg_ab), .pos(pos_ab)
    );

    tss_edge_stage #(.COORD_BITS(COORD_BITS), .MAX_GRID_SIDE(MAX_GRID_SIDE)) u_edge_bc (
        .aclk(aclk), .en(stage_en), .px(x0_reg), .py(y0_reg),
        .ux(bx_reg), .uy(by_reg), .vx(cx_reg), .vy(cy_reg),
        .side_log(sl), .neg(neg_bc), .pos(pos_bc)
    );

    tss_edge_stage #(.COORD_BITS(COORD_BITS), .MAX_GRID_SIDE(MAX_GRID_SIDE)) u_edge_ca (
        .aclk(aclk), .en(stage_en), .px(x0_reg), .py(y0_reg),
        .ux(cx_reg), .uy(cy_reg), .vx(ax_reg), .vy(ay_reg),
        .side_log(sl), .neg(neg_ca), .pos(pos_ca)
    );

    logic [NSLOT-1:0]          sub_hit;
    logic [2:0]                side_n;
    logic [CW-1:0]             total, count_next, covered_reg;
    logic [CW+7:0]             scaled;
    logic [tss_pkg::ALPHA_W-1:0] alpha_next, alpha_reg;
    tss_pkg::tss_action_t      action_next, action_reg;

    always_comb begin
        side_n = 3'd1 << sl;
        for (int k = 0; k < NSLOT; k++) begin
            sub_hit[k] = ((k % SIDE_N) < side_n) && ((k / SIDE_N) < side_n)
                       && !((neg_ab[k] | neg_bc[k] | neg_ca[k])
                            && (pos_ab[k] | pos_bc[k] | pos_ca[k]));
        end
        count_next = CW'($countones(sub_hit));
        total      = CW'(1) << {sl, 1'b0};
        scaled     = {count_next, 8'b0} - {8'b0, count_next};
        if (count_next == '0) begin
            action_next = tss_pkg::ACT_SKIP;
            alpha_next  = '0;
        end else if (count_next == total) begin
            action_next = tss_pkg::ACT_FULL;
            alpha_next  = '1;
        end else begin
            action_next = tss_pkg::ACT_BLEND;
            alpha_next  = tss_pkg::ALPHA_W'(scaled >> {sl, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            covered_reg <= count_next;
            alpha_reg   <= alpha_next;
            action_reg  <= action_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, covered_reg, alpha_reg, y4_reg, x4_reg};
    assign m_tuser  = action_reg;

    `TSS_ASSERT(a_full_alpha, aclk, aresetn, m_tvalid && (action_reg == tss_pkg::ACT_FULL) |-> (alpha_reg == 8'hFF), "Full write beat without full alpha.")
    `TSS_ASSERT(a_skip_count, aclk, aresetn, m_tvalid |-> ((action_reg == tss_pkg::ACT_SKIP) == (covered_reg == '0)), "Skip action disagrees with covered count.")
    `TSS_ASSERT(a_count_range, aclk, aresetn, m_tvalid |-> (covered_reg <= (CW'(1) << {sl, 1'b0})), "Covered count exceeds the number of subsamples.")
    `TSS_ASSERT(a_stall_full, aclk, aresetn, !s_tready |-> (v0_reg && v1_reg && v2_reg && v3_reg && v4_reg), "Input stalled while the pipeline has a bubble.")
    `TSS_ASSERT_NEXT(a_advance, aclk, aresetn, v3_reg && en4, m_tvalid, "Advancing beat did not reach the result register.")

endmodule

@@ tb/tss_coverage_checker.sv @@
`timescale 1ns / 1ps

module tss_coverage_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [tss_pkg::CFG_AW-1:0]    paddr,
    input  logic [tss_pkg::CFG_DW-1:0]    pwdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [23:0]                   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [39:0]                   m_tdata,
    input  logic [tss_pkg::ACTION_W-1:0]  m_tuser,
    output int                            pending,
    output int                            errors
);
    import tss_pkg::*;

    localparam int CB = COORD_BITS_DEF;

    typedef struct {
        logic [CB-1:0]        x;
        logic [CB-1:0]        y;
        tss_action_t          action;
        logic [ALPHA_W-1:0]   alpha;
        logic [COVERED_W-1:0] covered;
    } pixel_cover_t;

    logic signed [CB-1:0] vtx [6];
    logic [1:0]           grid_mode;
    pixel_cover_t         expected_coverage [$];
    int                   mismatch_cnt = 0;

    assign errors = mismatch_cnt;

    function automatic longint edge_value(longint qx, longint qy, longint ux, longint uy,
                                          longint vx, longint vy);
        return (qx - vx) * (uy - vy) - (ux - vx) * (qy - vy);
    endfunction

    function automatic pixel_cover_t coverage_of_pixel(logic [CB-1:0] x, logic [CB-1:0] y);
        pixel_cover_t r;
        longint ax, ay, bx, by, cx, cy, px, py, qx, qy, e1, e2, e3;
        int side, half, total, count;
        bit neg, pos;
        ax = 8 * longint'(vtx[0]);
        ay = 8 * longint'(vtx[1]);
        bx = 8 * longint'(vtx[2]);
        by = 8 * longint'(vtx[3]);
        cx = 8 * longint'(vtx[4]);
        cy = 8 * longint'(vtx[5]);
        px = 8 * longint'($signed(x));
        py = 8 * longint'($signed(y));
        if (grid_mode == GRID_1) begin
            side = 1;
        end else if (grid_mode == GRID_2) begin
            side = 2;
        end else begin
            side = 4;
        end
        while (side > MAX_GRID_SIDE_DEF && side > 1) begin
            side = side / 2;
        end
        half = 4 / side;
        total = side * side;
        count = 0;
        for (int sy = 0; sy < side; sy++) begin
            for (int sx = 0; sx < side; sx++) begin
                qx = px + (2 * sx + 1) * half;
                qy = py + (2 * sy + 1) * half;
                e1 = edge_value(qx, qy, ax, ay, bx, by);
                e2 = edge_value(qx, qy, bx, by, cx, cy);
                e3 = edge_value(qx, qy, cx, cy, ax, ay);
                neg = (e1 < 0) || (e2 < 0) || (e3 < 0);
                pos = (e1 > 0) || (e2 > 0) || (e3 > 0);
                if (!(neg && pos)) begin
                    count++;
                end
            end
        end
        r.x = x;
        r.y = y;
        r.covered = COVERED_W'(count);
        if (count == 0) begin
            r.action = ACT_SKIP;
            r.alpha = '0;
        end else if (count == total) begin
            r.action = ACT_FULL;
            r.alpha = 8'd255;
        end else begin
            r.action = ACT_BLEND;
            r.alpha = ALPHA_W'((count * 255) / total);
        end
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        pixel_cover_t want;
        if (!aresetn) begin
            foreach (vtx[i]) begin
                vtx[i] = '0;
            end
            grid_mode = GRID_4;
            expected_coverage.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (tss_reg_t'(paddr[4:2]))
                    REG_VERTEX_AX, REG_VERTEX_AY, REG_VERTEX_BX,
                    REG_VERTEX_BY, REG_VERTEX_CX, REG_VERTEX_CY: begin
                        vtx[paddr[4:2]] = pwdata[CB-1:0];
                    end
                    REG_GRID_MODE: begin
                        grid_mode = pwdata[1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_coverage.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got tdata %h tuser %0d",
                             $time, m_tdata, m_tuser);
                    mismatch_cnt++;
                end else begin
                    want = expected_coverage.pop_front();
                    check_field("out_x", longint'($signed(want.x)),
                                longint'($signed(m_tdata[CB-1:0])));
                    check_field("out_y", longint'($signed(want.y)),
                                longint'($signed(m_tdata[2*CB-1:CB])));
                    check_field("action", want.action, m_tuser);
                    check_field("alpha", want.alpha, m_tdata[2*CB+7:2*CB]);
                    check_field("covered", want.covered, m_tdata[2*CB+12:2*CB+8]);
                    check_field("tdata padding", 0, m_tdata[39:2*CB+13]);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_coverage.push_back(coverage_of_pixel(s_tdata[CB-1:0],
                                                              s_tdata[2*CB-1:CB]));
            end
        end
        pending <= expected_coverage.size();
    end

endmodule

@@ tb/tb_triangle_supersample_coverage.sv @@
`timescale 1ns / 1ps

module tb_triangle_supersample_coverage;
    import tss_pkg::*;

    localparam int HOLD_CYCLES         = 96;
    localparam int STALL_LIMIT         = 3000;
    localparam int PIXELS_PER_TRIANGLE = 25;
    localparam int TRIANGLES_PER_PHASE = 9;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam logic [1:0] GRID_SAT     = 2'd3;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_AW-1:0]     paddr    = '0;
    logic [CFG_DW-1:0]     pwdata   = '0;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic [ACTION_W-1:0]   m_tuser;

    int   pending_cnt;
    int   error_cnt;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_start    = 1'b0;
    logic hold_req      = 1'b0;
    int   quiet_cycles  = 0;
    int   bb_x0, bb_x1, bb_y0, bb_y1;

    always #4 aclk = ~aclk;

    triangle_supersample_coverage u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tss_coverage_checker u_chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .pending  (pending_cnt),
        .errors   (error_cnt)
    );

    always @(negedge aclk) begin
        m_tready <= !hold_req && ($urandom_range(0, 99) >= stall_pct);
    end

    always begin
        wait (hold_start);
        hold_req = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_req = 1'b0;
        wait (!hold_start);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("triangle_supersample_coverage regression: fail");
                $finish;
            end
        end
    end

    function automatic int clamp_coord(int v);
        return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
    endfunction

    function automatic logic [31:0] coord_word(int v);
        return ($urandom() & 32'hFFFF_F000) | (32'(v) & 32'h0000_0FFF);
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_triangle(int ax, int ay, int bx, int by, int cx, int cy,
                                logic [1:0] mode);
        cfg_write(REG_VERTEX_AX, coord_word(ax));
        cfg_write(REG_VERTEX_AY, coord_word(ay));
        cfg_write(REG_VERTEX_BX, coord_word(bx));
        cfg_write(REG_VERTEX_BY, coord_word(by));
        cfg_write(REG_VERTEX_CX, coord_word(cx));
        cfg_write(REG_VERTEX_CY, coord_word(cy));
        cfg_write(REG_GRID_MODE, ($urandom() & ~32'h3) | 32'(mode));
    endtask

    task automatic send_pixel(int x, int y);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {12'(y), 12'(x)};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_cnt == 0);
    endtask

    task automatic random_pixel();
        int x, y;
        if ($urandom_range(0, 99) < 85) begin
            x = clamp_coord(bb_x0 - 1 + int'($urandom_range(0, bb_x1 - bb_x0 + 2)));
            y = clamp_coord(bb_y0 - 1 + int'($urandom_range(0, bb_y1 - bb_y0 + 2)));
        end else begin
            x = int'($urandom_range(0, 4095)) - 2048;
            y = int'($urandom_range(0, 4095)) - 2048;
        end
        send_pixel(x, y);
    endtask

    task automatic random_triangle();
        int v[6];
        int kind, span, ox, oy, dx, dy, k, m;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            foreach (v[i]) begin
                v[i] = int'($urandom_range(0, 4095)) - 2048;
            end
        end else if (kind == 1) begin
            // Collinear vertices: the triangle has zero area.
            ox = int'($urandom_range(0, 4000)) - 2000;
            oy = int'($urandom_range(0, 4000)) - 2000;
            dx = int'($urandom_range(0, 16)) - 8;
            dy = int'($urandom_range(0, 16)) - 8;
            k  = int'($urandom_range(0, 6)) - 3;
            m  = int'($urandom_range(0, 6)) - 3;
            v  = '{ox, oy, ox + k * dx, oy + k * dy, ox + m * dx, oy + m * dy};
        end else begin
            case ($urandom_range(0, 4))
                0:       span = 1;
                1:       span = 2;
                2:       span = 4;
                3:       span = 10;
                default: span = 40;
            endcase
            ox = int'($urandom_range(0, 4095 - 2 * span)) - 2048 + span;
            oy = int'($urandom_range(0, 4095 - 2 * span)) - 2048 + span;
            for (int i = 0; i < 6; i += 2) begin
                v[i]     = ox + int'($urandom_range(0, 2 * span)) - span;
                v[i + 1] = oy + int'($urandom_range(0, 2 * span)) - span;
            end
        end
        bb_x0 = v[0];
        bb_x1 = v[0];
        bb_y0 = v[1];
        bb_y1 = v[1];
        for (int i = 2; i < 6; i += 2) begin
            bb_x0 = (v[i] < bb_x0) ? v[i] : bb_x0;
            bb_x1 = (v[i] > bb_x1) ? v[i] : bb_x1;
            bb_y0 = (v[i + 1] < bb_y0) ? v[i + 1] : bb_y0;
            bb_y1 = (v[i + 1] > bb_y1) ? v[i + 1] : bb_y1;
        end
        set_triangle(v[0], v[1], v[2], v[3], v[4], v[5], 2'($urandom_range(0, 3)));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // After reset all vertices coincide, so every pixel is fully covered.
        send_pixel(0, 0);
        send_pixel(-2048, -2048);
        send_pixel(2047, 2047);
        send_pixel(-2048, 2047);
        send_pixel(2047, -2048);

        drain();
        set_triangle(0, 0, 8, 0, 0, 8, GRID_4);
        cfg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_pixel(1, 1);
        send_pixel(20, 20);
        send_pixel(4, 3);
        send_pixel(3, 4);
        send_pixel(-1, -1);

        drain();
        cfg_write(REG_GRID_MODE, 32'(GRID_1));
        send_pixel(4, 3);
        send_pixel(3, 3);
        send_pixel(7, 0);

        drain();
        cfg_write(REG_GRID_MODE, 32'(GRID_2));
        send_pixel(4, 3);
        send_pixel(3, 4);
        send_pixel(0, 7);

        drain();
        cfg_write(REG_GRID_MODE, 32'(GRID_SAT));
        send_pixel(4, 3);
        send_pixel(3, 4);

        drain();
        set_triangle(-2048, -2048, -2048, 2047, 2047, -2048, GRID_4);
        send_pixel(-2048, -2048);
        send_pixel(2047, 2047);
        send_pixel(0, 0);
        send_pixel(-1, -1);
        send_pixel(2047, -2048);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 82;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 82;
                end
                default: begin
                    send_idle_pct = 10;
                    stall_pct = 10;
                end
            endcase
            for (int t = 0; t < TRIANGLES_PER_PHASE; t++) begin
                drain();
                random_triangle();
                if (phase == 0 && t == 2) begin
                    hold_start = 1'b1;
                end
                repeat (PIXELS_PER_TRIANGLE) random_pixel();
            end
        end

        drain();
        repeat (16) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("triangle_supersample_coverage regression: pass");
        end else begin
            $display("triangle_supersample_coverage regression: fail");
        end
        $finish;
    end

endmodule
